FILE: rtl/core/vfsp_pkg.sv
// Shared types and constants of the readout frame parser.
package vfsp_pkg;

    // Channel count of one front-end chip and the frame word layout
    localparam int CHANNELS      = 128;
    localparam int CH_WORDS      = CHANNELS / 16;
    localparam int FRAME_WORDS   = 12;

    // Link word codes
    localparam logic [15:0] PAD_WORD = 16'hFFFF;
    localparam logic [3:0]  TAG_BC   = 4'hA;
    localparam logic [3:0]  TAG_EC   = 4'hC;
    localparam logic [3:0]  TAG_ID   = 4'hE;
    localparam logic [3:0]  TAG_END  = 4'hF;

    // Frame word slots
    localparam logic [3:0] IDX_CRC  = 4'd0;
    localparam logic [3:0] IDX_CH8  = 4'd8;
    localparam logic [3:0] IDX_ID   = 4'd9;
    localparam logic [3:0] IDX_EC   = 4'd10;
    localparam logic [3:0] IDX_BC   = 4'd11;
    localparam logic [3:0] RAW_WORDS = 4'd9;

    // Configuration register indexes
    localparam logic CFG_CLUSTER_CODE = 1'b0;
    localparam logic CFG_RAW_CODE     = 1'b1;

    typedef enum logic [1:0] {
        ST_FRAME   = 2'd0,
        ST_BAD_SIG = 2'd1,
        ST_SIZE    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    // One unit of output work: a whole frame or a single status result
    typedef struct packed {
        t_status                  status;
        logic [11:0]              link_tag;
        logic [3:0]               goh_index;
        logic [3:0]               fiber_index;
        logic [3:0]               presence_flags;
        logic [3:0]               error_flags;
        logic [15:0]              value;
        logic [FRAME_WORDS-1:0][15:0] words;
    } t_job;

endpackage

FILE: rtl/core/vfsp_front.sv
// Front end: parses link words and builds frame or status jobs.
module vfsp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [15:0]      i_data_word,
    input  logic [11:0]      i_link_id,
    input  logic [7:0]       i_cluster_code,
    input  logic [7:0]       i_raw_code,
    output logic             o_job_valid,
    output vfsp_pkg::t_job   o_job
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_OPT_BC = 5'b00010,
        PH_OPT_EC = 5'b00100,
        PH_OPT_ID = 5'b01000,
        PH_DATA   = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_raw, n_raw;
    logic [11:0] r_link, n_link;
    logic [3:0]  r_goh, n_goh;
    logic [3:0]  r_fib, n_fib;
    logic [2:0]  r_pres, n_pres;
    logic [7:0]  r_seen, n_seen;
    logic [3:0]  r_rws, n_rws;
    logic [vfsp_pkg::FRAME_WORDS-1:0][15:0] r_fw, n_fw;

    logic [3:0]  tag;
    logic [7:0]  flag;
    logic [7:0]  seen_inc;
    logic [7:0]  clu_pos;
    logic [8:0]  clu_size;
    logic [8:0]  clu_top;
    logic [7:0]  clu_lo;
    logic        clu_ok;
    logic [vfsp_pkg::CHANNELS-1:0] hit;
    logic        do_data;
    logic        finish;

    assign tag      = i_data_word[15:12];
    assign flag     = i_data_word[15:8];
    assign seen_inc = (r_seen == 8'hFF) ? r_seen : r_seen + 8'd1;

    // Decode a cluster word into a channel hit mask
    assign clu_pos  = i_data_word[7:0];
    assign clu_size = (i_data_word[14:8] == 7'd0) ? 9'(vfsp_pkg::CHANNELS)
                                                  : {2'b00, i_data_word[14:8]};
    assign clu_top  = {1'b0, clu_pos} + 9'd1;
    assign clu_ok   = !clu_pos[7] && (clu_size <= clu_top);
    assign clu_lo   = 8'(clu_top - clu_size);

    always_comb begin
        for (int c = 0; c < vfsp_pkg::CHANNELS; c++) begin
            hit[c] = clu_ok && (8'(c) >= clu_lo) && (8'(c) <= clu_pos);
        end
    end

    // Advance the parser by one accepted word
    always_comb begin
        n_phase     = r_phase;
        n_raw       = r_raw;
        n_link      = r_link;
        n_goh       = r_goh;
        n_fib       = r_fib;
        n_pres      = r_pres;
        n_seen      = r_seen;
        n_rws       = r_rws;
        n_fw        = r_fw;
        do_data     = 1'b0;
        finish      = 1'b0;
        o_job_valid = 1'b0;
        o_job       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_data_word != vfsp_pkg::PAD_WORD) begin
                        if (flag == i_cluster_code || flag == i_raw_code) begin
                            n_raw   = (flag != i_cluster_code);
                            n_link  = i_link_id;
                            n_goh   = i_data_word[7:4];
                            n_fib   = i_data_word[3:0];
                            n_pres  = '0;
                            n_seen  = 8'd1;
                            n_rws   = '0;
                            n_fw    = '0;
                            n_phase = PH_OPT_BC;
                        end else begin
                            o_job_valid       = 1'b1;
                            o_job.status      = vfsp_pkg::ST_UNKNOWN;
                            o_job.link_tag    = i_link_id;
                            o_job.goh_index   = i_data_word[7:4];
                            o_job.fiber_index = i_data_word[3:0];
                            o_job.value       = i_data_word;
                        end
                    end
                end
                PH_OPT_BC, PH_OPT_EC, PH_OPT_ID: begin
                    if (r_phase == PH_OPT_BC && tag == vfsp_pkg::TAG_BC) begin
                        n_fw[vfsp_pkg::IDX_BC] = i_data_word;
                        n_pres[0] = 1'b1;
                        n_seen    = seen_inc;
                        n_phase   = PH_OPT_EC;
                    end else if ((r_phase == PH_OPT_BC || r_phase == PH_OPT_EC) &&
                                 tag == vfsp_pkg::TAG_EC) begin
                        n_fw[vfsp_pkg::IDX_EC] = i_data_word;
                        n_pres[1] = 1'b1;
                        n_seen    = seen_inc;
                        n_phase   = PH_OPT_ID;
                    end else begin
                        n_phase = PH_DATA;
                        if (tag == vfsp_pkg::TAG_ID) begin
                            n_fw[vfsp_pkg::IDX_ID] = i_data_word;
                            n_pres[2] = 1'b1;
                            n_seen    = seen_inc;
                        end else begin
                            do_data = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    do_data = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // Channel data: raw words or clusters until the trailer
            if (do_data) begin
                if (r_raw) begin
                    if (r_rws < vfsp_pkg::RAW_WORDS) begin
                        if (r_rws < vfsp_pkg::IDX_CH8) begin
                            n_fw[vfsp_pkg::IDX_CH8 - r_rws] = i_data_word;
                        end else begin
                            n_fw[vfsp_pkg::IDX_CRC] = i_data_word;
                        end
                        n_rws  = r_rws + 4'd1;
                        n_seen = seen_inc;
                    end else begin
                        finish = 1'b1;
                    end
                end else if (tag != vfsp_pkg::TAG_END) begin
                    for (int k = 0; k < vfsp_pkg::CH_WORDS; k++) begin
                        n_fw[k + 1] = r_fw[k + 1] | hit[16*k +: 16];
                    end
                    n_seen = seen_inc;
                end else begin
                    finish = 1'b1;
                end
            end

            // Trailer: check signature and size, hand the frame to the back end
            if (finish) begin
                n_seen              = seen_inc;
                n_phase             = PH_IDLE;
                o_job_valid         = 1'b1;
                o_job.link_tag      = r_link;
                o_job.goh_index     = r_goh;
                o_job.fiber_index   = r_fib;
                o_job.error_flags   = i_data_word[11:8];
                o_job.presence_flags = {1'b0, r_pres};
                o_job.words         = r_fw;
                if (tag != vfsp_pkg::TAG_END) begin
                    o_job.status = vfsp_pkg::ST_BAD_SIG;
                end else if (seen_inc == 8'hFF || i_data_word[7:0] != seen_inc) begin
                    o_job.status = vfsp_pkg::ST_SIZE;
                end else begin
                    o_job.status = vfsp_pkg::ST_FRAME;
                    o_job.presence_flags = {r_raw, r_pres};
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_raw   <= 1'b0;
            r_pres  <= '0;
            r_seen  <= '0;
            r_rws   <= '0;
            r_fw    <= '0;
        end else begin
            r_phase <= n_phase;
            r_raw   <= n_raw;
            r_pres  <= n_pres;
            r_seen  <= n_seen;
            r_rws   <= n_rws;
            r_fw    <= n_fw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
        r_goh  <= n_goh;
        r_fib  <= n_fib;
    end

endmodule

FILE: rtl/core/vfsp_job_queue.sv
// Short job queue between the parser and the result emitter.
module vfsp_job_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vfsp_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output vfsp_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vfsp_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/vfsp_emitter.sv
// Back end: walks one job at a time and presents its result beats.
module vfsp_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  vfsp_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_beat_pop,
    output logic           o_busy,
    output logic [1:0]     o_status,
    output logic [11:0]    o_link_tag,
    output logic [3:0]     o_goh_index,
    output logic [3:0]     o_fiber_index,
    output logic [3:0]     o_presence_flags,
    output logic [3:0]     o_error_flags,
    output logic [3:0]     o_word_index,
    output logic [15:0]    o_word_value,
    output logic           o_last
);

    logic           r_busy;
    vfsp_pkg::t_job r_job;
    logic [3:0]     r_idx;
    logic           is_frame;
    logic           take;

    assign is_frame = (r_job.status == vfsp_pkg::ST_FRAME);
    assign o_last   = !is_frame || (r_idx == vfsp_pkg::IDX_BC);
    assign take     = !r_busy || (i_beat_pop && o_last);
    assign o_job_pop = take && i_job_valid;

    // Load the next job while idle or once the current one has delivered its last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= i_job_valid;
            r_idx  <= '0;
        end else if (i_beat_pop) begin
            r_idx  <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
    end

    // Present the current beat
    assign o_busy           = r_busy;
    assign o_status         = r_job.status;
    assign o_link_tag       = r_job.link_tag;
    assign o_goh_index      = r_job.goh_index;
    assign o_fiber_index    = r_job.fiber_index;
    assign o_presence_flags = r_job.presence_flags;
    assign o_error_flags    = r_job.error_flags;
    assign o_word_index     = r_idx;
    assign o_word_value     = is_frame ? r_job.words[r_idx] : r_job.value;

endmodule

FILE: rtl/core/vfat_frame_stream_parser.sv
// A job from a header or trailer word is stored in the queue, then in the emitter.
// Throughput: one link word per cycle while the job queue has room; each frame takes
// 12 result pops, each status one pop, from a single emitter behind a JOB_DEPTH queue.
// full rises when JOB_DEPTH jobs wait in the queue.
// Reset: synchronous, active low; parser goes idle, queue and emitter empty,
// mode codes return to 128 (cluster) and 144 (raw).
module vfat_frame_stream_parser #(
    parameter int JOB_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_data_word,
    input  logic [11:0] i_link_id,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [11:0] o_link_tag,
    output logic [3:0]  o_goh_index,
    output logic [3:0]  o_fiber_index,
    output logic [3:0]  o_presence_flags,
    output logic [3:0]  o_error_flags,
    output logic [3:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]     r_cluster_code;
    logic [7:0]     r_raw_code;
    logic           accept;
    logic           job_valid;
    vfsp_pkg::t_job job;
    logic           q_ready;
    logic           q_valid;
    vfsp_pkg::t_job q_job;
    logic           q_pop;
    logic           busy;

    // Hold the mode codes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_code <= 8'd128;
            r_raw_code     <= 8'd144;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vfsp_pkg::CFG_CLUSTER_CODE: r_cluster_code <= i_cfg_data;
                vfsp_pkg::CFG_RAW_CODE:     r_raw_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall the link while the queue is full
    assign full   = !q_ready;
    assign accept = push && !full;
    assign empty  = !busy;

    vfsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_word    (i_data_word),
        .i_link_id      (i_link_id),
        .i_cluster_code (r_cluster_code),
        .i_raw_code     (r_raw_code),
        .o_job_valid    (job_valid),
        .o_job          (job)
    );

    vfsp_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    vfsp_emitter u_emitter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (q_valid),
        .i_job            (q_job),
        .o_job_pop        (q_pop),
        .i_beat_pop       (pop && busy),
        .o_busy           (busy),
        .o_status         (o_status),
        .o_link_tag       (o_link_tag),
        .o_goh_index      (o_goh_index),
        .o_fiber_index    (o_fiber_index),
        .o_presence_flags (o_presence_flags),
        .o_error_flags    (o_error_flags),
        .o_word_index     (o_word_index),
        .o_word_value     (o_word_value),
        .o_last           (o_last)
    );

`ifndef ASSERT_OFF
    // A job is only produced while the queue can take it
    a_job_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> q_ready)
        else $error("job produced while queue full");

    // A status beat stands alone at word index zero
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != vfsp_pkg::ST_FRAME) |->
            (o_last && o_word_index == vfsp_pkg::IDX_CRC))
        else $error("status beat not single");

    // Last beat of a frame is the BC word
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == vfsp_pkg::ST_FRAME && o_last) |->
            (o_word_index == vfsp_pkg::IDX_BC))
        else $error("frame ended early");

    // A popped frame beat advances the word index
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_status == vfsp_pkg::ST_FRAME && !o_last) |=>
            (!empty && o_word_index == $past(o_word_index) + 4'd1))
        else $error("frame beat skipped");
`endif

endmodule
